[src/wof_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel odometry filter package
// Widths, register indexes, payload structs and controller states shared by
// the odometry filter and its digit-serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package wof_pkg;

   // Field widths.
   localparam int COUNT_WIDTH    = 16;
   localparam int DISTANCE_WIDTH = 48;
   localparam int GAIN_WIDTH     = 24;
   localparam int RADIUS_WIDTH   = 16;
   localparam int PERIOD_WIDTH   = 16;
   localparam int RATE_WIDTH     = 32;
   localparam int SPEED_WIDTH    = 32;
   localparam int STEP_WIDTH     = 32;
   localparam int LENGTH_WIDTH   = 48;

   // Fraction bits dropped after the speed and distance products.
   localparam int RADIUS_FRAC = 8;
   localparam int PERIOD_FRAC = 16;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 24;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RADIUS = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PERIOD = 2'd2;

   localparam logic [GAIN_WIDTH-1:0]   GAIN_RESET   = 24'd65536;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 16'd768;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd328;

   // Operation codes.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Digit-serial arithmetic.
   localparam int DIGIT_WIDTH      = 4;
   localparam int GAIN_DIGITS      = (GAIN_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int RADIUS_DIGITS    = (RADIUS_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int PERIOD_DIGITS    = (PERIOD_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int MPLIER_WIDTH     = GAIN_DIGITS * DIGIT_WIDTH;
   localparam int DIGIT_CNT_WIDTH  = $clog2(GAIN_DIGITS + 1);

   // The product register holds count * gain as well as rate * radius and
   // speed * period.
   localparam int RAW_PROD_WIDTH = COUNT_WIDTH + GAIN_WIDTH;
   localparam int SPD_PROD_WIDTH = RATE_WIDTH + RADIUS_WIDTH;
   localparam int PROD_WIDTH     = (RAW_PROD_WIDTH > SPD_PROD_WIDTH) ?
                                   RAW_PROD_WIDTH : SPD_PROD_WIDTH;

   // Filter sum raw + 4 * old and its division by five.
   localparam int SUM_WIDTH     = RATE_WIDTH + 3;
   localparam int DIV_DIGITS    = (SUM_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int DIV_WIDTH     = DIV_DIGITS * DIGIT_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_DIGITS + 1);
   localparam int REM_WIDTH     = 3;

   typedef struct packed {
      logic                          op;
      logic signed [COUNT_WIDTH-1:0] left_count;
      logic signed [COUNT_WIDTH-1:0] right_count;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0]  left_speed;
      logic signed [SPEED_WIDTH-1:0]  right_speed;
      logic signed [LENGTH_WIDTH-1:0] total_length;
      logic signed [LENGTH_WIDTH-1:0] delta_length;
   } rsp_type;

   typedef struct packed {
      logic                       start;
      logic [DIGIT_CNT_WIDTH-1:0] digits;
   } mul_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW_GO,
      ST_RAW_WAIT,
      ST_SUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SPEED_GO,
      ST_SPEED_WAIT,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_DIST,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[src/wof_mul.sv]
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed multiplicand times unsigned multiplier, one 4-bit multiplier digit
// per cycle, least significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module wof_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wof_pkg::mul_cmd_type                   cmd,
   input  logic signed [wof_pkg::PROD_WIDTH-1:0]  mcand,
   input  logic [wof_pkg::MPLIER_WIDTH-1:0]       mplier,
   output logic                                   done,
   output logic signed [wof_pkg::PROD_WIDTH-1:0]  product
);
   import wof_pkg::*;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [DIGIT_CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic signed [PROD_WIDTH-1:0]   acc_ff, acc_in;
   logic signed [PROD_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [MPLIER_WIDTH-1:0]        mplier_ff, mplier_in;

   logic signed [PROD_WIDTH+DIGIT_WIDTH:0] partial;
   logic signed [PROD_WIDTH-1:0]           term;

   always_comb begin
      // Only the low bits matter: the finished product always fits.
      partial = mcand_ff * $signed({1'b0, mplier_ff[DIGIT_WIDTH-1:0]});
      term    = partial[PROD_WIDTH-1:0];

      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = cmd.digits;
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
      end else if (busy_ff) begin
         acc_in    = acc_ff + term;
         mcand_in  = mcand_ff <<< DIGIT_WIDTH;
         mplier_in = mplier_ff >> DIGIT_WIDTH;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == DIGIT_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

[src/wof_div5.sv]
// ----------------------------------------------------------------------------
// Digit-serial divide by five
// Rounds a signed sum divided by five to nearest, ties away from zero.
// Long division one 4-bit digit per cycle, most significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module wof_div5 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [wof_pkg::SUM_WIDTH-1:0]  dividend,
   output logic                                  done,
   output logic signed [wof_pkg::RATE_WIDTH-1:0] quotient
);
   import wof_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                       neg_ff, neg_in;
   logic [REM_WIDTH-1:0]       rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]       mag_ff, mag_in;

   logic signed [DIV_WIDTH-1:0]          ext;
   logic [DIV_WIDTH-1:0]                 mag_start;
   logic [REM_WIDTH+DIGIT_WIDTH-1:0]     window;
   logic [10:0]                          est_full;
   logic [4:0]                           est;
   logic [7:0]                           est_x5;
   logic [7:0]                           diff;
   logic [DIGIT_WIDTH-1:0]               qdigit;
   logic [REM_WIDTH-1:0]                 rdigit;
   logic [RATE_WIDTH-1:0]                q_mag;

   always_comb begin
      // Magnitude plus two, so that truncating division rounds to nearest.
      ext       = DIV_WIDTH'(dividend);
      mag_start = dividend[SUM_WIDTH-1] ? (DIV_WIDTH'(2) - ext) : (ext + DIV_WIDTH'(2));

      // window / 5 for a window below 80: 13/64 overestimates by at most one.
      window   = {rem_ff, mag_ff[DIV_WIDTH-1 -: DIGIT_WIDTH]};
      est_full = (11'(window) * 11'd13) >> 6;
      est      = est_full[4:0];
      est_x5   = 8'(est) * 8'd5;
      diff     = 8'(window) - est_x5;
      if (diff[7]) begin
         qdigit = DIGIT_WIDTH'(est - 5'd1);
         rdigit = REM_WIDTH'(diff + 8'd5);
      end else begin
         qdigit = DIGIT_WIDTH'(est);
         rdigit = REM_WIDTH'(diff);
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      mag_in  = mag_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_WIDTH'(DIV_DIGITS);
         neg_in  = dividend[SUM_WIDTH-1];
         rem_in  = '0;
         mag_in  = mag_start;
      end else if (busy_ff) begin
         // Quotient digits enter at the bottom as dividend digits leave the top.
         mag_in = {mag_ff[DIV_WIDTH-DIGIT_WIDTH-1:0], qdigit};
         rem_in = rdigit;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      q_mag    = mag_ff[RATE_WIDTH-1:0];
      quotient = neg_ff ? (RATE_WIDTH'(0) - q_mag) : q_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
   end

   assign done = done_ff;

endmodule

`default_nettype wire

[src/wheel_odometry_filter_top.sv]
// ----------------------------------------------------------------------------
// Wheel odometry filter
// Filters left and right encoder rates, converts them to speeds and
// integrates per-wheel distance; reports speeds, mean and half-difference.
// ----------------------------------------------------------------------------
// One item is in work at a time: a request is taken only in idle, after the
// last one's response has been loaded. On a tick each wheel in turn runs
// count*gain (6 digits), the divide by five (9 digits), rate*radius and
// speed*period (4 digits each); on a clear only rate*radius. They share
// one 4-bit digit-serial multiplier and one divider.
// Reset: registers to their defaults, rates and distances to zero.
`default_nettype none

module wheel_odometry_filter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wof_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wof_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [wof_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [wof_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import wof_pkg::*;

   localparam logic WHEEL_LEFT  = 1'b0;
   localparam logic WHEEL_RIGHT = 1'b1;
   localparam int   DSUM_WIDTH  = DISTANCE_WIDTH + 1;
   localparam int   EXT_WIDTH   = (DISTANCE_WIDTH > LENGTH_WIDTH) ?
                                  DISTANCE_WIDTH : LENGTH_WIDTH;
   localparam logic [DISTANCE_WIDTH-1:0] DIST_MAX = {1'b0, {(DISTANCE_WIDTH-1){1'b1}}};
   localparam logic [DISTANCE_WIDTH-1:0] DIST_MIN = {1'b1, {(DISTANCE_WIDTH-1){1'b0}}};

   function automatic logic signed [SPEED_WIDTH-1:0] sat32(
      input logic signed [PROD_WIDTH-1:0] x);
      logic all_ones;
      logic all_zeros;
      all_ones  = &x[PROD_WIDTH-1:SPEED_WIDTH-1];
      all_zeros = ~|x[PROD_WIDTH-1:SPEED_WIDTH-1];
      if (all_ones || all_zeros) begin
         sat32 = x[SPEED_WIDTH-1:0];
      end else if (x[PROD_WIDTH-1]) begin
         sat32 = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
      end
   endfunction

   // Control and state.
   state_type                        state_ff, state_in;
   logic                             wheel_ff, wheel_in;
   logic                             op_ff, op_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [GAIN_WIDTH-1:0]            gain_ff, gain_in;
   logic [RADIUS_WIDTH-1:0]          radius_ff, radius_in;
   logic [PERIOD_WIDTH-1:0]          period_ff, period_in;
   logic signed [RATE_WIDTH-1:0]     rate_left_ff, rate_left_in;
   logic signed [RATE_WIDTH-1:0]     rate_right_ff, rate_right_in;
   logic signed [DISTANCE_WIDTH-1:0] dist_left_ff, dist_left_in;
   logic signed [DISTANCE_WIDTH-1:0] dist_right_ff, dist_right_in;

   // Working payload.
   logic signed [COUNT_WIDTH-1:0]    left_count_ff, left_count_in;
   logic signed [COUNT_WIDTH-1:0]    right_count_ff, right_count_in;
   logic signed [SUM_WIDTH-1:0]      sum_ff, sum_in;
   logic signed [STEP_WIDTH-1:0]     step_ff, step_in;
   logic signed [SPEED_WIDTH-1:0]    speed_left_ff, speed_left_in;
   logic signed [SPEED_WIDTH-1:0]    speed_right_ff, speed_right_in;
   rsp_type                          rsp_data_ff, rsp_data_in;

   // Arithmetic unit interface.
   mul_cmd_type                      mul_cmd;
   logic signed [PROD_WIDTH-1:0]     mul_mcand;
   logic [MPLIER_WIDTH-1:0]          mul_mplier;
   logic                             mul_done;
   logic signed [PROD_WIDTH-1:0]     prod;
   logic                             div_start;
   logic                             div_done;
   logic signed [RATE_WIDTH-1:0]     div_quot;

   // Datapath.
   logic signed [COUNT_WIDTH-1:0]    cur_count;
   logic signed [RATE_WIDTH-1:0]     cur_rate;
   logic signed [SPEED_WIDTH-1:0]    cur_speed;
   logic signed [DISTANCE_WIDTH-1:0] cur_dist;
   logic signed [SPEED_WIDTH-1:0]    raw_sat;
   logic signed [PROD_WIDTH-1:0]     speed_round;
   logic signed [PROD_WIDTH-1:0]     speed_shift;
   logic signed [PROD_WIDTH-1:0]     step_round;
   logic signed [DSUM_WIDTH-1:0]     dist_sum;
   logic signed [DISTANCE_WIDTH-1:0] dist_next;
   logic signed [DSUM_WIDTH-1:0]     len_sum;
   logic signed [DSUM_WIDTH-1:0]     len_diff;
   logic signed [EXT_WIDTH-1:0]      total_ext;
   logic signed [EXT_WIDTH-1:0]      delta_ext;
   state_type                        state_after_wheel;
   logic                             rsp_load;

   wof_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (prod)
   );

   wof_div5 u_div5 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Configuration writes.
   always_comb begin
      gain_in   = gain_ff;
      radius_in = radius_ff;
      period_in = period_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_GAIN:   gain_in   = csr_wdata[GAIN_WIDTH-1:0];
            CSR_RADIUS: radius_in = csr_wdata[RADIUS_WIDTH-1:0];
            CSR_PERIOD: period_in = csr_wdata[PERIOD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Per-wheel operand selection and the arithmetic between unit results.
   always_comb begin
      cur_count = (wheel_ff == WHEEL_RIGHT) ? right_count_ff : left_count_ff;
      cur_rate  = (wheel_ff == WHEEL_RIGHT) ? rate_right_ff  : rate_left_ff;
      cur_speed = (wheel_ff == WHEEL_RIGHT) ? speed_right_ff : speed_left_ff;
      cur_dist  = (wheel_ff == WHEEL_RIGHT) ? dist_right_ff  : dist_left_ff;

      raw_sat = sat32(prod);

      // Round to nearest with ties toward plus infinity, then drop fraction.
      speed_round = prod + PROD_WIDTH'(1 << (RADIUS_FRAC - 1));
      speed_shift = speed_round >>> RADIUS_FRAC;
      step_round  = prod + PROD_WIDTH'(1 << (PERIOD_FRAC - 1));

      dist_sum = DSUM_WIDTH'(cur_dist) + DSUM_WIDTH'(step_ff);
      if (dist_sum[DISTANCE_WIDTH] != dist_sum[DISTANCE_WIDTH-1]) begin
         dist_next = dist_sum[DISTANCE_WIDTH] ? DIST_MIN : DIST_MAX;
      end else begin
         dist_next = dist_sum[DISTANCE_WIDTH-1:0];
      end

      // The extra bit keeps the sum exact; the arithmetic halving floors.
      len_sum   = DSUM_WIDTH'(dist_left_ff) + DSUM_WIDTH'(dist_right_ff);
      len_diff  = DSUM_WIDTH'(dist_left_ff) - DSUM_WIDTH'(dist_right_ff);
      total_ext = EXT_WIDTH'($signed(len_sum[DISTANCE_WIDTH:1]));
      delta_ext = EXT_WIDTH'($signed(len_diff[DISTANCE_WIDTH:1]));

      if (wheel_ff == WHEEL_LEFT) begin
         state_after_wheel = (op_ff == OP_CLEAR) ? ST_SPEED_GO : ST_RAW_GO;
      end else begin
         state_after_wheel = ST_DONE;
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      wheel_in       = wheel_ff;
      op_in          = op_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      rate_left_in   = rate_left_ff;
      rate_right_in  = rate_right_ff;
      dist_left_in   = dist_left_ff;
      dist_right_in  = dist_right_ff;
      sum_in         = sum_ff;
      step_in        = step_ff;
      speed_left_in  = speed_left_ff;
      speed_right_in = speed_right_ff;
      rsp_data_in    = rsp_data_ff;
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      div_start      = 1'b0;
      mul_cmd        = '0;
      mul_mcand      = '0;
      mul_mplier     = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in          = req_data.op;
               left_count_in  = req_data.left_count;
               right_count_in = req_data.right_count;
               wheel_in       = WHEEL_LEFT;
               if (req_data.op == OP_CLEAR) begin
                  dist_left_in  = '0;
                  dist_right_in = '0;
                  state_in      = ST_SPEED_GO;
               end else begin
                  state_in = ST_RAW_GO;
               end
            end
         end
         ST_RAW_GO: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.digits = DIGIT_CNT_WIDTH'(GAIN_DIGITS);
            mul_mcand      = PROD_WIDTH'(cur_count);
            mul_mplier     = MPLIER_WIDTH'(gain_ff);
            state_in       = ST_RAW_WAIT;
         end
         ST_RAW_WAIT: begin
            if (mul_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = SUM_WIDTH'(raw_sat) + (SUM_WIDTH'(cur_rate) <<< 2);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (wheel_ff == WHEEL_RIGHT) begin
                  rate_right_in = div_quot;
               end else begin
                  rate_left_in = div_quot;
               end
               state_in = ST_SPEED_GO;
            end
         end
         ST_SPEED_GO: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.digits = DIGIT_CNT_WIDTH'(RADIUS_DIGITS);
            mul_mcand      = PROD_WIDTH'(cur_rate);
            mul_mplier     = MPLIER_WIDTH'(radius_ff);
            state_in       = ST_SPEED_WAIT;
         end
         ST_SPEED_WAIT: begin
            if (mul_done) begin
               if (wheel_ff == WHEEL_RIGHT) begin
                  speed_right_in = sat32(speed_shift);
               end else begin
                  speed_left_in = sat32(speed_shift);
               end
               if (op_ff == OP_CLEAR) begin
                  wheel_in = WHEEL_RIGHT;
                  state_in = state_after_wheel;
               end else begin
                  state_in = ST_STEP_GO;
               end
            end
         end
         ST_STEP_GO: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.digits = DIGIT_CNT_WIDTH'(PERIOD_DIGITS);
            mul_mcand      = PROD_WIDTH'(cur_speed);
            mul_mplier     = MPLIER_WIDTH'(period_ff);
            state_in       = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (mul_done) begin
               step_in  = step_round[PERIOD_FRAC +: STEP_WIDTH];
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (wheel_ff == WHEEL_RIGHT) begin
               dist_right_in = dist_next;
            end else begin
               dist_left_in = dist_next;
            end
            wheel_in = WHEEL_RIGHT;
            state_in = state_after_wheel;
         end
         ST_DONE: begin
            // Wait here only while the previous result has not been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load                 = 1'b1;
               rsp_data_in.left_speed   = speed_left_ff;
               rsp_data_in.right_speed  = speed_right_ff;
               rsp_data_in.total_length = total_ext[LENGTH_WIDTH-1:0];
               rsp_data_in.delta_length = delta_ext[LENGTH_WIDTH-1:0];
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff      <= WHEEL_LEFT;
         op_ff         <= OP_TICK;
         rsp_valid_ff  <= 1'b0;
         gain_ff       <= GAIN_RESET;
         radius_ff     <= RADIUS_RESET;
         period_ff     <= PERIOD_RESET;
         rate_left_ff  <= '0;
         rate_right_ff <= '0;
         dist_left_ff  <= '0;
         dist_right_ff <= '0;
      end else begin
         wheel_ff      <= wheel_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         gain_ff       <= gain_in;
         radius_ff     <= radius_in;
         period_ff     <= period_in;
         rate_left_ff  <= rate_left_in;
         rate_right_ff <= rate_right_in;
         dist_left_ff  <= dist_left_in;
         dist_right_ff <= dist_right_in;
      end
   end

   always_ff @(posedge clock) begin
      left_count_ff  <= left_count_in;
      right_count_ff <= right_count_in;
      sum_ff         <= sum_in;
      step_ff        <= step_in;
      speed_left_ff  <= speed_left_in;
      speed_right_ff <= speed_right_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The multiplier and the divider are never both finishing at once.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   // No arithmetic unit finishes while no item is in work.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_done && !div_done)
      else $error("arithmetic unit finished outside an item");

   // A clear always reports both lengths as zero.
   a_clear_lengths: assert property (@(posedge clock) disable iff (reset)
      rsp_load && op_ff == OP_CLEAR |=>
         rsp_data_ff.total_length == '0 && rsp_data_ff.delta_length == '0)
      else $error("clear response carries nonzero length");

   // Every accepted item starts with the left wheel.
   a_left_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> wheel_ff == WHEEL_LEFT)
      else $error("item did not start on the left wheel");

endmodule

`default_nettype wire

[verif/wheel_odometry_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// Wheel odometry filter testbench
// Drives encoder ticks and distance clears into the odometry filter, predicts
// the filtered speeds and wheel travel in fixed point, and checks every
// response field against the prediction under random idling and a long
// response stall.
// ----------------------------------------------------------------------------
module wheel_odometry_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wof_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam longint I32_MAX    = 64'sd2147483647;
   localparam longint I32_MIN    = -I32_MAX - 1;
   localparam longint TRAVEL_MAX = (longint'(1) <<< (DISTANCE_WIDTH - 1)) - 1;
   localparam longint TRAVEL_MIN = -TRAVEL_MAX - 1;
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = 16'sh8000;
   localparam int SETTLE_CYCLES = 80;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   int send_idle_pct   = 14;
   int recv_idle_pct   = 80;
   int hold_cycles_req = 0;
   int hold_req_id     = 0;
   int hold_id_seen    = 0;
   int hold_left       = 0;
   int fail_count      = 0;

   // Predicted filter state and register settings.
   logic [GAIN_WIDTH-1:0]   gain_setting   = GAIN_RESET;
   logic [RADIUS_WIDTH-1:0] radius_setting = RADIUS_RESET;
   logic [PERIOD_WIDTH-1:0] period_setting = PERIOD_RESET;
   longint rate_left    = 0;
   longint rate_right   = 0;
   longint travel_left  = 0;
   longint travel_right = 0;

   rsp_type expected_odometry[$];

   wheel_odometry_filter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clamp(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Divide by 2^n, rounding to nearest with ties toward plus infinity.
   function automatic longint round_half_up(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint filtered_rate(longint prior,
                                            logic signed [COUNT_WIDTH-1:0] counts);
      longint raw;
      longint sum;
      raw = clamp(longint'(counts) * longint'(gain_setting), I32_MIN, I32_MAX);
      sum = raw + 4 * prior;
      // One fifth new, four fifths old, rounded half away from zero.
      if (sum >= 0)
         return (sum + 2) / 5;
      return -((-sum + 2) / 5);
   endfunction

   function automatic longint wheel_speed(longint rate);
      return clamp(round_half_up(rate * longint'(radius_setting), RADIUS_FRAC),
                   I32_MIN, I32_MAX);
   endfunction

   function automatic longint accumulate_travel(longint travel, longint speed);
      longint step;
      step = round_half_up(speed * longint'(period_setting), PERIOD_FRAC);
      return clamp(travel + step, TRAVEL_MIN, TRAVEL_MAX);
   endfunction

   function automatic rsp_type predict_odometry(req_type item);
      longint  speed_l;
      longint  speed_r;
      longint  mean_len;
      longint  half_diff;
      rsp_type r;
      if (item.op == OP_CLEAR) begin
         travel_left  = 0;
         travel_right = 0;
      end else begin
         rate_left  = filtered_rate(rate_left, item.left_count);
         rate_right = filtered_rate(rate_right, item.right_count);
      end
      speed_l = wheel_speed(rate_left);
      speed_r = wheel_speed(rate_right);
      if (item.op == OP_TICK) begin
         travel_left  = accumulate_travel(travel_left, speed_l);
         travel_right = accumulate_travel(travel_right, speed_r);
      end
      mean_len  = (travel_left + travel_right) >>> 1;
      half_diff = (travel_left - travel_right) >>> 1;
      r.left_speed   = speed_l[SPEED_WIDTH-1:0];
      r.right_speed  = speed_r[SPEED_WIDTH-1:0];
      r.total_length = mean_len[LENGTH_WIDTH-1:0];
      r.delta_length = half_diff[LENGTH_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic signed [COUNT_WIDTH-1:0] random_count();
      case ($urandom_range(3))
         0:       return COUNT_WIDTH'($urandom());
         1:       return COUNT_WIDTH'($urandom_range(512) - 256);
         2: begin
            case ($urandom_range(3))
               0:       return COUNT_MAX;
               1:       return COUNT_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return COUNT_WIDTH'($urandom_range(40) - 20);
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge with valid still high,
   // so the caller either sends again or lowers valid in the same step.
   task automatic send_item(input logic op,
                            input logic signed [COUNT_WIDTH-1:0] lc,
                            input logic signed [COUNT_WIDTH-1:0] rc);
      req_type item;
      item.op          = op;
      item.left_count  = lc;
      item.right_count = rc;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_odometry.push_back(predict_odometry(item));
      @(negedge clock);
   endtask

   task automatic finish_pending();
      req_valid <= 1'b0;
      while (expected_odometry.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_GAIN:   gain_setting   = data[GAIN_WIDTH-1:0];
         CSR_RADIUS: radius_setting = data[RADIUS_WIDTH-1:0];
         CSR_PERIOD: period_setting = data[PERIOD_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_default_config();
      send_item(OP_TICK, 16'sd0, 16'sd0);
      send_item(OP_TICK, COUNT_MAX, COUNT_MIN);
      send_item(OP_TICK, COUNT_MIN, COUNT_MAX);
      send_item(OP_CLEAR, random_count(), random_count());
      send_item(OP_TICK, 16'sd1, -16'sd1);
      send_item(OP_TICK, -16'sd1, 16'sd1);
      send_item(OP_TICK, 16'sd100, 16'sd50);
      finish_pending();
   endtask

   // Full-scale settings drive the raw rate and the speed into saturation.
   task automatic test_saturation();
      write_csr(CSR_GAIN, {CSR_DATA_WIDTH{1'b1}});
      write_csr(CSR_RADIUS, {CSR_DATA_WIDTH{1'b1}});
      write_csr(CSR_PERIOD, {CSR_DATA_WIDTH{1'b1}});
      repeat (5) send_item(OP_TICK, COUNT_MAX, COUNT_MIN);
      send_item(OP_CLEAR, COUNT_MAX, COUNT_MAX);
      send_item(OP_TICK, 16'sd0, 16'sd0);
      repeat (2) send_item(OP_TICK, COUNT_MIN, COUNT_MAX);
      finish_pending();
   endtask

   task automatic test_zero_config();
      write_csr(CSR_GAIN, '0);
      write_csr(CSR_RADIUS, '0);
      write_csr(CSR_PERIOD, '0);
      repeat (2) send_item(OP_TICK, COUNT_MAX, COUNT_MAX);
      send_item(OP_CLEAR, COUNT_MIN, COUNT_MIN);
      finish_pending();
   endtask

   task automatic test_unused_register();
      write_csr(CSR_RADIUS, CSR_DATA_WIDTH'(RADIUS_RESET));
      write_csr(CSR_PERIOD, CSR_DATA_WIDTH'(PERIOD_RESET));
      write_csr(CSR_SPARE, CSR_DATA_WIDTH'($urandom()));
      send_item(OP_TICK, 16'sd1000, -16'sd1000);
      send_item(OP_CLEAR, random_count(), random_count());
      finish_pending();
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_WIDTH-1:0] gain;
      logic [CSR_DATA_WIDTH-1:0] radius;
      logic [CSR_DATA_WIDTH-1:0] period;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (4) begin
            case ($urandom_range(3))
               0:       gain = CSR_DATA_WIDTH'($urandom_range(24'hFFFFFF));
               1:       gain = CSR_DATA_WIDTH'($urandom_range(4095));
               2:       gain = GAIN_RESET;
               default: gain = ($urandom_range(1) != 0) ? {CSR_DATA_WIDTH{1'b1}} : '0;
            endcase
            radius = ($urandom_range(1) != 0) ? CSR_DATA_WIDTH'($urandom()) :
                                                CSR_DATA_WIDTH'(RADIUS_RESET);
            period = ($urandom_range(1) != 0) ? CSR_DATA_WIDTH'($urandom()) :
                                                CSR_DATA_WIDTH'(PERIOD_RESET);
            write_csr(CSR_GAIN, gain);
            write_csr(CSR_RADIUS, radius);
            write_csr(CSR_PERIOD, period);
            repeat (52)
               send_item(($urandom_range(9) == 0) ? OP_CLEAR : OP_TICK,
                         random_count(), random_count());
            finish_pending();
         end
      end
   endtask

   // The response side stalls long enough that the block holds its input off
   // while the sender keeps offering ticks.
   task automatic test_backpressure();
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      hold_cycles_req = 400;
      hold_req_id++;
      repeat (12) send_item(OP_TICK, random_count(), random_count());
      finish_pending();
   endtask

   always @(negedge clock) begin
      if (hold_req_id != hold_id_seen) begin
         hold_id_seen = hold_req_id;
         hold_left    = hold_cycles_req;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_odometry.size() == 0) begin
            $error("response transfer with no expected result");
            fail_count++;
         end else begin
            want = expected_odometry.pop_front();
            if (rsp_data.left_speed !== want.left_speed) begin
               $error("left_speed: expected %0d, actual %0d",
                      want.left_speed, rsp_data.left_speed);
               fail_count++;
            end
            if (rsp_data.right_speed !== want.right_speed) begin
               $error("right_speed: expected %0d, actual %0d",
                      want.right_speed, rsp_data.right_speed);
               fail_count++;
            end
            if (rsp_data.total_length !== want.total_length) begin
               $error("total_length: expected %0d, actual %0d",
                      want.total_length, rsp_data.total_length);
               fail_count++;
            end
            if (rsp_data.delta_length !== want.delta_length) begin
               $error("delta_length: expected %0d, actual %0d",
                      want.delta_length, rsp_data.delta_length);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_config();
      test_saturation();
      test_zero_config();
      test_unused_register();
      test_random_traffic();
      test_backpressure();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_odometry.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

[wheel_odometry_filter_top.f]
src/wof_pkg.sv
src/wof_mul.sv
src/wof_div5.sv
src/wheel_odometry_filter_top.sv
verif/wheel_odometry_filter_top_tb.sv
